// ===== design/bayer_demosaic_half_scale_core_macros.svh =====
// Assertion macros used by the checker file, bdhs_checker.sv.
`ifndef BAYER_DEMOSAIC_HALF_SCALE_CORE_MACROS_SVH
`define BAYER_DEMOSAIC_HALF_SCALE_CORE_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define BDHS_ASSERT_IMP(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while dis is high.
`define BDHS_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bdhs_pkg.sv =====
package bdhs_pkg;

  localparam int PIX_W         = 10;
  localparam int CLR_W         = 12;
  localparam int COORD_W       = 11;
  localparam int ROW_W         = 12;
  localparam int CFG_W         = 13;
  localparam int CFG_IDX_W     = 1;
  localparam int LS_W          = 3 * PIX_W;
  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MIN_DIM       = 4;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 64;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd3280;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd2464;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // 4x4 neighbourhood, indexed [row][col], row 0 / col 0 oldest
  typedef logic [3:0][3:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [CLR_W-1:0] blue;
    logic [CLR_W-1:0] green;
    logic [CLR_W-1:0] red;
  } rgb_t;

endpackage

// ===== design/bdhs_ram.sv =====
module bdhs_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];  // read-first
    end
  end

endmodule

// ===== design/bdhs_interp.sv =====
// Bilinear R/G/B at the four sites of the centre cell, summed over the cell.
module bdhs_interp (
  input  bdhs_pkg::win_t p,
  output bdhs_pkg::rgb_t rgb
);
  import bdhs_pkg::*;

  function automatic logic [CLR_W-1:0] half2(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
    logic [PIX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return CLR_W'(s[PIX_W:1]);
  endfunction

  function automatic logic [CLR_W-1:0] quar4(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c,
                                             input logic [PIX_W-1:0] d);
    logic [PIX_W+1:0] s;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
    return CLR_W'(s[PIX_W+1:2]);
  endfunction

  always_comb begin
    // red sits at p[1][1]
    rgb.red = CLR_W'(p[1][1]) + half2(p[1][1], p[1][3]) + half2(p[1][1], p[3][1])
            + quar4(p[1][1], p[1][3], p[3][1], p[3][3]);
    // greens at p[1][2] and p[2][1]
    rgb.green = quar4(p[0][1], p[1][0], p[2][1], p[1][2]) + CLR_W'(p[1][2])
              + CLR_W'(p[2][1]) + quar4(p[1][2], p[2][3], p[3][2], p[2][1]);
    // blue at p[2][2]
    rgb.blue = quar4(p[0][0], p[2][0], p[0][2], p[2][2]) + half2(p[0][2], p[2][2])
             + half2(p[2][0], p[2][2]) + CLR_W'(p[2][2]);
  end

endmodule

// ===== design/bayer_demosaic_half_scale_core.sv =====
// Channel   Direction  Payload (lowest bit first)                          Handshake
// s_axis    in         tdata: pixel[9:0], zero pad to 16                    tvalid/tready
// m_axis    out        tdata: red, green, blue, out_row, out_col, pad to 64 tvalid/tready
//                      tlast: frame_done
// cfg       in         cfg_addr 0 frame_width, 1 frame_height              cfg_wr_en
//
// One pixel per clock unless a stalled output holds a result; results pass stage 1, then the
// output register. The rate is set by the line store: one read, one write port, registered read.
// rst (synchronous) clears counters, window, pipeline and output valid and reloads the frame size;
// the line store is not cleared and is fully written by the first rows.
// A stalled output only blocks input when the waiting stage holds a result.
module bayer_demosaic_half_scale_core #(
  parameter int MAX_WIDTH = bdhs_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // raw pixel stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bdhs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [9:0] pixel
  // half-scale RGB stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [bdhs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // red, green, blue, row, col
  output logic                                m_axis_tlast,   // frame_done
  // register writes
  input  logic                                cfg_wr_en,
  input  logic [bdhs_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [bdhs_pkg::CFG_W-1:0]          cfg_wdata
);
  import bdhs_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);            // column counter / line store address
  localparam int WW = $clog2(MAX_WIDTH + 1);        // effective width
  localparam int EW = (CFG_W > WW) ? CFG_W : WW;    // clamp compare width
  localparam int CX = CW + COORD_W;

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  frame_width  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height <= cfg_wdata;
        default:          frame_width  <= frame_width;
      endcase
    end
  end

  // clamped frame size and last odd anchor positions
  logic [EW-1:0]    fw_x;
  logic [WW-1:0]    w_eff;
  logic [CFG_W-1:0] h_eff;
  logic [WW-1:0]    w_last;
  logic [CFG_W-1:0] h_last;

  always_comb begin
    fw_x = EW'(frame_width);
    if (fw_x < EW'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (fw_x > EW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_x);
    end
    if (frame_height < CFG_W'(MIN_DIM)) begin
      h_eff = CFG_W'(MIN_DIM);
    end else if (frame_height > CFG_W'(MAX_HEIGHT)) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
    w_last = w_eff[0] ? w_eff - WW'(2) : w_eff - WW'(1);
    h_last = h_eff[0] ? h_eff - CFG_W'(2) : h_eff - CFG_W'(1);
  end

  // ---------------- stage 0: raster position ----------------
  logic [CW-1:0]    col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic             in_xact;
  logic             col_wrap;
  logic             row_wrap;
  logic             has_res;
  logic             is_last;
  logic [ROW_W-1:0] rdiff;
  logic [CX-1:0]    cdiff;

  assign in_xact  = s_axis_tvalid && s_axis_tready;
  assign col_wrap = (WW'(col_cnt) + WW'(1)) >= w_eff;
  assign row_wrap = (CFG_W'(row_cnt) + CFG_W'(1)) >= h_eff;

  // anchor at odd row/col >= 3, inside the current frame size
  assign has_res = row_cnt[0] && col_cnt[0]
                && (row_cnt[ROW_W-1:1] != '0) && (col_cnt[CW-1:1] != '0)
                && (CFG_W'(row_cnt) < h_eff) && (WW'(col_cnt) < w_eff);
  assign is_last = (CFG_W'(row_cnt) == h_last) && (WW'(col_cnt) == w_last);
  assign rdiff   = row_cnt - ROW_W'(3);
  assign cdiff   = CX'(col_cnt) - CX'(3);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_xact) begin
      if (col_wrap) begin
        col_cnt <= '0;
        row_cnt <= row_wrap ? '0 : row_cnt + ROW_W'(1);
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  // ---------------- stage 1: line store read data, window, interpolation --------
  logic               s1_valid;
  logic [PIX_W-1:0]   s1_px;
  logic [CW-1:0]      s1_col_cnt;
  logic               s1_res;
  logic               s1_last;
  logic [COORD_W-1:0] s1_row;
  logic [COORD_W-1:0] s1_col;
  logic               s1_adv;

  // result stage only holds back when it has a result and the output register is full and not taken
  assign s1_adv        = s1_valid && (!s1_res || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xact) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xact) begin
      s1_px      <= s_axis_tdata[PIX_W-1:0];
      s1_col_cnt <= col_cnt;
      s1_res     <= has_res;
      s1_last    <= is_last;
      s1_row     <= rdiff[ROW_W-1:1];
      s1_col     <= cdiff[COORD_W:1];
    end
  end

  // Line store: three previous rows per column. Read issued on the input
  // transaction, so the read data holds while stage 1 waits. The write of one
  // item and the read of the next never share an address (width >= 4).
  logic [LS_W-1:0] ls_rdata;
  logic [LS_W-1:0] ls_wdata;

  assign ls_wdata = {ls_rdata[2*PIX_W-1:0], s1_px};

  bdhs_ram #(
    .WIDTH (LS_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_cnt),
    .wdata (ls_wdata),
    .re    (in_xact),
    .raddr (col_cnt),
    .rdata (ls_rdata)
  );

  // new column, oldest row first
  logic [3:0][PIX_W-1:0] new_col;
  assign new_col[0] = ls_rdata[3*PIX_W-1:2*PIX_W];
  assign new_col[1] = ls_rdata[2*PIX_W-1:PIX_W];
  assign new_col[2] = ls_rdata[PIX_W-1:0];
  assign new_col[3] = s1_px;

  // three previous columns, four rows each; index [column][row]
  logic [PIX_W-1:0] win [3][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 4; i++) begin
          win[j][i] <= '0;
        end
      end
    end else if (s1_adv) begin
      for (int i = 0; i < 4; i++) begin
        win[0][i] <= win[1][i];
        win[1][i] <= win[2][i];
        win[2][i] <= new_col[i];
      end
    end
  end

  win_t nbhd;
  rgb_t rgb;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nbhd[i][0] = win[0][i];
      nbhd[i][1] = win[1][i];
      nbhd[i][2] = win[2][i];
      nbhd[i][3] = new_col[i];
    end
  end

  bdhs_interp u_interp (
    .p   (nbhd),
    .rgb (rgb)
  );

  // ---------------- output register ----------------
  rgb_t               out_rgb;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv && s1_res) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_res) begin
      out_rgb  <= rgb;
      out_row  <= s1_row;
      out_col  <= s1_col;
      out_last <= s1_last;
    end
  end

  assign m_axis_tdata = {(OUT_TDATA_W - 3*CLR_W - 2*COORD_W)'(0), out_col, out_row,
                         out_rgb.blue, out_rgb.green, out_rgb.red};
  assign m_axis_tlast = out_last;

endmodule

// ===== design/bdhs_checker.sv =====
`include "bayer_demosaic_half_scale_core_macros.svh"

module bdhs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [bdhs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);
  import bdhs_pkg::*;

  logic                 out_stall;
  logic [OUT_TDATA_W:0] out_word;
  logic                 clr_ok;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tlast, m_axis_tdata};

  // each colour is a sum of four 10-bit estimates
  assign clr_ok = (m_axis_tdata[CLR_W-1:0] <= 12'd4092)
               && (m_axis_tdata[2*CLR_W-1:CLR_W] <= 12'd4092)
               && (m_axis_tdata[3*CLR_W-1:2*CLR_W] <= 12'd4092);

  // a waiting result stays offered, unchanged
  `BDHS_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_axis_tvalid, "output valid dropped")
  `BDHS_ASSERT_NEXT(a_out_stable, clk, rst, out_stall, $stable(out_word), "stalled output moved")

  // nothing is offered straight after reset
  `BDHS_ASSERT_IMP(a_rst_clear, clk, 1'b0, $past(rst), !m_axis_tvalid, "output valid after reset")

  `BDHS_ASSERT_IMP(a_clr_range, clk, rst, m_axis_tvalid, clr_ok, "colour out of range")

endmodule

bind bayer_demosaic_half_scale_core bdhs_checker u_bdhs_checker (.*);

// ===== tb/tb_bayer_demosaic_half_scale_core.sv =====
`timescale 1ns / 100ps

module tb_bayer_demosaic_half_scale_core;
  import bdhs_pkg::*;

  localparam int SETTLE_CYCLES = 8;     // idle cycles before a register write
  localparam int IDLE_PCT      = 28;    // chance of a bubble / stall per cycle, in percent
  localparam int STEADY_FROM   = 300;   // window of cycles with no bubbles on either side
  localparam int STEADY_TO     = 600;
  localparam int RANDOM_PIXELS = 400;

  typedef enum logic {OP_PIXEL, OP_WRITE} feed_op_e;

  // one queued stimulus step: a raw sample, or a register write done while idle
  typedef struct {
    feed_op_e             op;
    logic [CFG_IDX_W-1:0] addr;
    logic [CFG_W-1:0]     value;
  } feed_t;

  // one half-scale output pixel
  typedef struct packed {
    logic [CLR_W-1:0]   red;
    logic [CLR_W-1:0]   green;
    logic [CLR_W-1:0]   blue;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               done;
  } half_px_t;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [9:0] pixel
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // red, green, blue, out_row, out_col
  logic                   m_axis_tlast;         // frame_done
  logic                   cfg_wr_en     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr      = '0;
  logic [CFG_W-1:0]       cfg_wdata     = '0;

  feed_t    feed_q[$];      // pending stimulus, filled up front
  half_px_t half_px_q[$];   // predicted output pixels, oldest first
  half_px_t due_px;
  int       mismatches   = 0;
  int       cyc          = 0;
  int       quiet_cycles = 0;
  bit       pixel_out;
  bit       write_now;

  // predictor's own copy of the registers and state
  logic [CFG_W-1:0] width_reg  = FRAME_WIDTH_RST;
  logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RST;
  logic [LS_W-1:0]  line_mem [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] win_px [12];
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;

  // raster position as the stimulus generator sees it, so it knows frame boundaries
  int unsigned gen_w, gen_h;
  int unsigned gen_c = 0;
  int unsigned gen_r = 0;
  int unsigned pixels_queued = 0;

  bayer_demosaic_half_scale_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cyc <= cyc + 1;

  function automatic int unsigned clamp_dim(int unsigned raw, int unsigned hi);
    if (raw < MIN_DIM) return MIN_DIM;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic int unsigned last_odd(int unsigned n);
    return (n % 2 == 1) ? n - 2 : n - 1;
  endfunction

  // bubble / stall decision, switched off inside the steady window
  function automatic bit take_gap();
    if (cyc >= STEADY_FROM && cyc < STEADY_TO) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // Half-scale demosaic of one accepted sample: 4x4 window of rows r-3..r and
  // columns c-3..c, BGGR tiling so red at odd/odd. Every partial average floors.
  task automatic demosaic_step(input logic [PIX_W-1:0] px);
    int unsigned      w, h, c, r, rs, gs, bs;
    logic [LS_W-1:0]  old;
    int unsigned      p [4][4];
    half_px_t         px_out;
    w   = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h   = clamp_dim(height_reg, MAX_HEIGHT);
    c   = col_pos;
    r   = row_pos;
    old = (c < MAX_WIDTH_DEF) ? line_mem[c] : '0;
    for (int i = 0; i < 4; i++) begin
      p[i][0] = 32'(win_px[i]);
      p[i][1] = 32'(win_px[4 + i]);
      p[i][2] = 32'(win_px[8 + i]);
    end
    p[0][3] = 32'(old[3*PIX_W-1:2*PIX_W]);
    p[1][3] = 32'(old[2*PIX_W-1:PIX_W]);
    p[2][3] = 32'(old[PIX_W-1:0]);
    p[3][3] = 32'(px);

    if (r >= 3 && c >= 3 && r % 2 == 1 && c % 2 == 1 && r < h && c < w) begin
      rs = p[1][1] + ((p[1][1] + p[1][3]) >> 1) + ((p[1][1] + p[3][1]) >> 1)
         + ((p[1][1] + p[1][3] + p[3][1] + p[3][3]) >> 2);
      gs = ((p[0][1] + p[1][0] + p[2][1] + p[1][2]) >> 2) + p[1][2] + p[2][1]
         + ((p[1][2] + p[2][3] + p[3][2] + p[2][1]) >> 2);
      bs = ((p[0][0] + p[2][0] + p[0][2] + p[2][2]) >> 2) + ((p[0][2] + p[2][2]) >> 1)
         + ((p[2][0] + p[2][2]) >> 1) + p[2][2];
      px_out.red   = rs[CLR_W-1:0];
      px_out.green = gs[CLR_W-1:0];
      px_out.blue  = bs[CLR_W-1:0];
      px_out.row   = COORD_W'((r - 3) >> 1);
      px_out.col   = COORD_W'((c - 3) >> 1);
      px_out.done  = (r == last_odd(h) && c == last_odd(w));
      half_px_q.push_back(px_out);
    end

    for (int i = 0; i < 4; i++) begin
      win_px[i]     = win_px[4 + i];
      win_px[4 + i] = win_px[8 + i];
      win_px[8 + i] = PIX_W'(p[i][3]);
    end
    if (c < MAX_WIDTH_DEF) line_mem[c] = {old[2*PIX_W-1:0], px};

    // counters wrap once at or past the limit, so a mid-frame shrink is absorbed
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // ---------------------------------------------------------------- generator
  task automatic push_pixel(input logic [PIX_W-1:0] v);
    feed_t f;
    f.op    = OP_PIXEL;
    f.addr  = '0;
    f.value = CFG_W'(v);
    feed_q.push_back(f);
    pixels_queued++;
    if (gen_c + 1 >= gen_w) begin
      gen_c = 0;
      gen_r = (gen_r + 1 >= gen_h) ? 0 : gen_r + 1;
    end else begin
      gen_c++;
    end
  endtask

  task automatic push_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned raw);
    feed_t f;
    f.op    = OP_WRITE;
    f.addr  = idx;
    f.value = raw[CFG_W-1:0];
    feed_q.push_back(f);
    if (idx == REG_FRAME_WIDTH) gen_w = clamp_dim(raw % 8192, MAX_WIDTH_DEF);
    else gen_h = clamp_dim(raw % 8192, MAX_HEIGHT);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(bit flat, logic [PIX_W-1:0] level);
    if (flat) return level;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // from a boundary this queues a whole frame, from mid-frame the remainder
  task automatic run_to_frame_end(input bit flat, input logic [PIX_W-1:0] level);
    do begin
      push_pixel(pick_pixel(flat, level));
    end while (gen_c != 0 || gen_r != 0);
  endtask

  // ---------------------------------------------------------------- driver
  // Pixels go out with random bubbles. A register write waits until the input
  // is idle, no output is outstanding and the pipe has had time to empty: this
  // also gives the required pauses in which every pending result drains.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      cfg_wr_en     <= 1'b0;
      cfg_addr      <= '0;
      cfg_wdata     <= '0;
      quiet_cycles  = 0;
    end else begin
      write_now = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        demosaic_step(s_axis_tdata[PIX_W-1:0]);
        quiet_cycles = 0;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        pixel_out = 1'b0;
        if (feed_q.size() != 0) begin
          if (feed_q[0].op == OP_PIXEL) begin
            if (!take_gap()) begin
              s_axis_tdata <= {{(IN_TDATA_W-PIX_W){1'b0}}, feed_q[0].value[PIX_W-1:0]};
              pixel_out = 1'b1;
              void'(feed_q.pop_front());
            end
          end else if (!s_axis_tvalid && half_px_q.size() == 0) begin
            if (quiet_cycles >= SETTLE_CYCLES) begin
              write_now = 1'b1;
              cfg_addr  <= feed_q[0].addr;
              cfg_wdata <= feed_q[0].value;
              if (feed_q[0].addr == REG_FRAME_WIDTH) width_reg = feed_q[0].value;
              else height_reg = feed_q[0].value;
              void'(feed_q.pop_front());
              quiet_cycles = 0;
            end else begin
              quiet_cycles++;
            end
          end else begin
            quiet_cycles = 0;
          end
        end
        s_axis_tvalid <= pixel_out;
      end
      cfg_wr_en <= write_now;
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic check_field(input string name, input logic [CLR_W-1:0] want,
                             input logic [CLR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // each output transaction is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (half_px_q.size() == 0) begin
          $error("output transaction with no pixel predicted, tdata %h", m_axis_tdata);
          mismatches++;
        end else begin
          due_px = half_px_q.pop_front();
          check_field("red", due_px.red, m_axis_tdata[CLR_W-1:0]);
          check_field("green", due_px.green, m_axis_tdata[2*CLR_W-1:CLR_W]);
          check_field("blue", due_px.blue, m_axis_tdata[3*CLR_W-1:2*CLR_W]);
          check_field("out_row", CLR_W'(due_px.row),
                      CLR_W'(m_axis_tdata[3*CLR_W+COORD_W-1:3*CLR_W]));
          check_field("out_col", CLR_W'(due_px.col),
                      CLR_W'(m_axis_tdata[3*CLR_W+2*COORD_W-1:3*CLR_W+COORD_W]));
          check_field("frame_done", CLR_W'(due_px.done), CLR_W'(m_axis_tlast));
        end
      end
      m_axis_tready <= !take_gap();
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin
    int unsigned      rand_from, cut;
    bit               flat, first;
    logic [PIX_W-1:0] level;
    for (int i = 0; i < MAX_WIDTH_DEF; i++) line_mem[i] = '0;
    for (int i = 0; i < 12; i++) win_px[i] = '0;
    gen_w = clamp_dim(FRAME_WIDTH_RST, MAX_WIDTH_DEF);
    gen_h = clamp_dim(FRAME_HEIGHT_RST, MAX_HEIGHT);

    // Saturated cell: start a row at the reset size, then shrink mid-row so the
    // column counter sits past the new width and wraps. Width below the minimum
    // clamps to 4; height 5 is odd, so its last result carries frame_done.
    repeat (4) push_pixel('1);
    push_write(REG_FRAME_WIDTH, 0);
    push_write(REG_FRAME_HEIGHT, 5);
    repeat (13) push_pixel('1);
    push_pixel(10'h000);
    push_pixel(10'h155);
    push_pixel(10'h2AA);
    push_pixel(10'h3FF);

    // width above the limit clamps to the maximum; shrink part way along the
    // first row so the frame ends as a 4x4 one
    push_write(REG_FRAME_WIDTH, 8191);
    push_write(REG_FRAME_HEIGHT, 4);
    repeat (6) push_pixel(pick_pixel(1'b0, '0));
    push_write(REG_FRAME_WIDTH, 4);
    run_to_frame_end(1'b0, '0);

    // height above the limit clamps; shrinking it below the current row leaves
    // that row without results and wraps at its end
    push_write(REG_FRAME_HEIGHT, 8191);
    repeat (28) push_pixel(pick_pixel(1'b0, '0));
    push_write(REG_FRAME_HEIGHT, 4);
    run_to_frame_end(1'b0, '0);

    // small random frames, some back to back, some resized part way through
    rand_from = pixels_queued;
    first     = 1'b1;
    while (pixels_queued - rand_from < RANDOM_PIXELS) begin
      if (first || $urandom_range(0, 1) == 0) begin
        push_write(REG_FRAME_WIDTH, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3)
                                                                : $urandom_range(4, 14));
        push_write(REG_FRAME_HEIGHT, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3)
                                                                 : $urandom_range(4, 12));
        first = 1'b0;
      end
      flat  = ($urandom_range(0, 15) == 0);
      level = ($urandom_range(0, 1) == 0) ? PIX_W'($urandom_range(0, 1023))
                                          : ($urandom_range(0, 1) ? {PIX_W{1'b1}}
                                                                  : {PIX_W{1'b0}});
      if ($urandom_range(0, 3) == 0) begin
        // mid-frame resize: width never grows, height either way
        cut = $urandom_range(1, gen_w * gen_h - 1);
        repeat (cut) push_pixel(pick_pixel(flat, level));
        if ($urandom_range(0, 1) == 0) push_write(REG_FRAME_WIDTH, $urandom_range(0, gen_w));
        else push_write(REG_FRAME_HEIGHT, $urandom_range(0, 14));
      end
      run_to_frame_end(flat, level);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // sampled on the falling edge, clear of the rising-edge updates
    while (feed_q.size() != 0 || s_axis_tvalid || half_px_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #200_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
